FILE: sv/mcrl_pkg.sv
package mcrl_pkg;

  localparam int unsigned RING_CAP = 256;

  typedef logic [8:0]  ring_cnt_t;
  typedef logic [7:0]  slot_t;
  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    REQ_SCAN = 2'd0,
    REQ_DONE = 2'd1,
    REQ_SAVE = 2'd2
  } req_type_t;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_REPORT = 1'b1
  } result_kind_t;

  localparam logic REG_RING_RECORDS = 1'b0;
  localparam ring_cnt_t RING_RECORDS_RESET = 9'd256;

  // slot after s in a ring of n slots
  function automatic slot_t next_slot(input ring_cnt_t s, input ring_cnt_t n);
    ring_cnt_t inc;
    inc = s + 9'd1;
    next_slot = (inc >= n) ? 8'd0 : inc[7:0];
  endfunction

endpackage

FILE: sv/monotonic_counter_ring_log.sv
// Counter ring log: a scan pass over the stored records (req_type 0, slot 0
// first) finds the last good duplicated record; a scan-done transaction
// (req_type 1) returns that slot and value as a report and arms the save
// pointer after it. Save transactions (req_type 2) return a write command for
// the next ring slot when the value differs from the last one saved or
// recovered. One transaction is taken per clock while in_stall is low: the item
// is decoded against the state registers combinationally and the result lands
// in the output register at the edge that accepts it. in_stall is raised only
// while a result sits in the output register and out_stall holds it. The ring
// size comes from register 0 (byte address 0), clamped to 1..256 and to
// MAX_RECORDS.
module monotonic_counter_ring_log #(
  parameter int unsigned MAX_RECORDS = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_req_type,
  input  logic [31:0]            in_record_first,
  input  logic [31:0]            in_record_second,
  input  logic [31:0]            in_save_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_result_kind,
  output logic [7:0]             out_slot,
  output logic [31:0]            out_value,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  import mcrl_pkg::*;

  ring_cnt_t ring_size;

  mcrl_regs #(.MAX_RECORDS(MAX_RECORDS)) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .ring_size  (ring_size)
  );

  ring_cnt_t    scan_count_r, scan_count_nxt;
  word_t        scan_latest_r, scan_latest_nxt;
  logic         scan_stopped_r, scan_stopped_nxt;
  word_t        tail_value_r, tail_value_nxt;
  slot_t        write_slot_r, write_slot_nxt;
  word_t        last_saved_r, last_saved_nxt;

  logic         out_valid_r;
  result_kind_t out_kind_r, out_kind_nxt;
  slot_t        out_slot_r, out_slot_nxt;
  word_t        out_value_r, out_value_nxt;
  logic         emit;

  logic         accept;
  ring_cnt_t    rpt_slot;
  ring_cnt_t    save_slot;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    scan_count_nxt   = scan_count_r;
    scan_latest_nxt  = scan_latest_r;
    scan_stopped_nxt = scan_stopped_r;
    tail_value_nxt   = tail_value_r;
    write_slot_nxt   = write_slot_r;
    last_saved_nxt   = last_saved_r;
    out_kind_nxt     = KIND_WRITE;
    out_slot_nxt     = 8'd0;
    out_value_nxt    = 32'd0;
    emit             = 1'b0;
    rpt_slot         = ring_size - 9'd1;
    save_slot        = 9'd0;

    if (scan_count_r != 9'd0 && (scan_count_r - 9'd1) < ring_size) begin
      rpt_slot = scan_count_r - 9'd1;
    end
    if ({1'b0, write_slot_r} < ring_size) begin
      save_slot = {1'b0, write_slot_r};
    end

    case (in_req_type)
      REQ_SCAN: begin
        tail_value_nxt = in_record_second;
        if (!scan_stopped_r) begin
          if (scan_count_r >= ring_size || in_record_first != in_record_second ||
              in_record_first < scan_latest_r) begin
            scan_stopped_nxt = 1'b1;
          end else begin
            scan_latest_nxt = in_record_first;
            scan_count_nxt  = scan_count_r + 9'd1;
          end
        end
      end
      REQ_DONE: begin
        emit             = 1'b1;
        out_kind_nxt     = KIND_REPORT;
        out_slot_nxt     = rpt_slot[7:0];
        out_value_nxt    = (scan_count_r == 9'd0) ? tail_value_r : scan_latest_r;
        write_slot_nxt   = next_slot(rpt_slot, ring_size);
        last_saved_nxt   = out_value_nxt;
        scan_count_nxt   = 9'd0;
        scan_latest_nxt  = 32'd0;
        scan_stopped_nxt = 1'b0;
        tail_value_nxt   = 32'd0;
      end
      REQ_SAVE: begin
        if (in_save_value != last_saved_r) begin
          emit           = 1'b1;
          out_kind_nxt   = KIND_WRITE;
          out_slot_nxt   = save_slot[7:0];
          out_value_nxt  = in_save_value;
          write_slot_nxt = next_slot(save_slot, ring_size);
          last_saved_nxt = in_save_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_count_r   <= 9'd0;
      scan_latest_r  <= 32'd0;
      scan_stopped_r <= 1'b0;
      tail_value_r   <= 32'd0;
      write_slot_r   <= 8'd0;
      last_saved_r   <= 32'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        scan_count_r   <= scan_count_nxt;
        scan_latest_r  <= scan_latest_nxt;
        scan_stopped_r <= scan_stopped_nxt;
        tail_value_r   <= tail_value_nxt;
        write_slot_r   <= write_slot_nxt;
        last_saved_r   <= last_saved_nxt;
        out_valid_r    <= emit;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a transaction produces one
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind_r  <= out_kind_nxt;
      out_slot_r  <= out_slot_nxt;
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_slot        = out_slot_r;
  assign out_value       = out_value_r;

  a_done_reports: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == REQ_DONE |=> out_valid_r && out_kind_r == KIND_REPORT)
    else $error("scan-done transaction did not produce a report");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_count_r <= 9'd256)
    else $error("scan count beyond ring capacity");

  // a pending result always carries the most recently saved or recovered value
  a_out_matches_saved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_value_r == last_saved_r)
    else $error("pending result value differs from last saved value");

endmodule

FILE: sv/mcrl_regs.sv
module mcrl_regs #(
  parameter int unsigned MAX_RECORDS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready,
  output mcrl_pkg::ring_cnt_t  ring_size
);
  import mcrl_pkg::*;

  localparam int unsigned LIMIT = (MAX_RECORDS < RING_CAP) ? MAX_RECORDS : RING_CAP;
  localparam ring_cnt_t LIMIT_CNT = ring_cnt_t'(LIMIT);

  ring_cnt_t ring_records_r;
  ring_cnt_t clamped;
  logic      reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == REG_RING_RECORDS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_records_r <= RING_RECORDS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      ring_records_r <= cfg_pwdata[8:0];
    end
  end

  assign cfg_prdata = reg_sel ? {23'd0, ring_records_r} : 32'd0;

  always_comb begin
    clamped = ring_records_r;
    if (clamped == 9'd0) begin
      clamped = 9'd1;
    end
    if (clamped > LIMIT_CNT) begin
      clamped = LIMIT_CNT;
    end
  end

  assign ring_size = clamped;

endmodule
